### hw/rtl/sah_pkg.sv
// ----------------------------------------------------------------------------
// sah_pkg: shared types and constants
// Field widths, cost arithmetic widths and the controller/datapath command
// and status bundles of the SAH sweep split finder.
// ----------------------------------------------------------------------------
`default_nettype none

package sah_pkg;

  localparam int COORD_W = 16;
  localparam int ID_W    = 16;
  localparam int EXT_W   = 16;
  localparam int PROD_W  = 2 * EXT_W;
  localparam int AREA_W  = 36;
  localparam int COST_W  = 44;
  localparam int LEFT_W  = 7;
  localparam int AXIS_W  = 2;
  localparam int VEC_W   = 3 * COORD_W;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [COST_W-1:0] COST_ONES = {COST_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic ld_we;       // store the accepted primitive
    logic key_idx_ld;  // latch index of the primitive being ranked
    logic key_ld;      // latch its center from the center store
    logic cmp_en;      // compare one center against the key
    logic ord_we;      // write rank result into the order store
    logic box_first;   // start the running box
    logic box_grow;    // grow the running box
    logic mul_en;      // extent products
    logic sum_en;      // surface area
    logic suf_we;      // write suffix area
    logic suf_ld;      // capture suffix area for the cost
    logic cost_en;     // weighted left and right areas
    logic best_upd;    // compare against the best cost
    logic best_clr;    // clear the best split
    logic emit;        // order store reads the best axis
    logic out_ld;      // load the output register
    logic out_inv;     // result of an unusable split
    logic out_last;    // final result of the run
  } sah_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic split_ok;
  } sah_sts_t;

  // Pick one axis out of a packed {z, y, x} vector
  function automatic logic signed [COORD_W-1:0] axis_pick(
    input logic [VEC_W-1:0]  vec,
    input logic [AXIS_W-1:0] axis
  );
    logic signed [COORD_W-1:0] r;
    case (axis)
      AXIS_Y:  r = vec[2*COORD_W-1:COORD_W];
      AXIS_Z:  r = vec[3*COORD_W-1:2*COORD_W];
      default: r = vec[COORD_W-1:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sah_ram.sv
// ----------------------------------------------------------------------------
// sah_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sah_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/sah_datapath.sv
// ----------------------------------------------------------------------------
// sah_datapath: stores, rank counter, box sweep and cost unit
// Holds the primitive stores, the per-axis order store and the suffix area
// store, and runs the operations the controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sah_datapath #(
  parameter int MAX_PRIMS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sah_pkg::sah_cmd_t                   cmd,
  input  wire logic [$clog2(MAX_PRIMS)-1:0]        idx,
  input  wire logic [sah_pkg::AXIS_W-1:0]          axis,
  input  wire logic [$clog2(MAX_PRIMS+1)-1:0]      n,
  output sah_pkg::sah_sts_t                        sts,
  input  wire logic [15:0]                         in_prim_id,
  input  wire logic signed [15:0]                  in_min_x,
  input  wire logic signed [15:0]                  in_min_y,
  input  wire logic signed [15:0]                  in_min_z,
  input  wire logic signed [15:0]                  in_max_x,
  input  wire logic signed [15:0]                  in_max_y,
  input  wire logic signed [15:0]                  in_max_z,
  input  wire logic signed [15:0]                  in_center_x,
  input  wire logic signed [15:0]                  in_center_y,
  input  wire logic signed [15:0]                  in_center_z,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [15:0]                              out_prim_id,
  output logic                                     out_split_valid,
  output logic [6:0]                               out_left_count,
  output logic [1:0]                               out_best_axis,
  output logic                                     out_last_out
);
  import sah_pkg::*;

  localparam int AW = $clog2(MAX_PRIMS);
  localparam int CW = $clog2(MAX_PRIMS + 1);
  localparam int OW = AW + AXIS_W;
  localparam int MW = AREA_W + CW;

  // RAM ports
  logic [ID_W-1:0]   id_rdata;
  logic [VEC_W-1:0]  min_rdata, max_rdata, ctr_rdata;
  logic [AW-1:0]     ord_rdata;
  logic [AREA_W-1:0] suf_rdata;
  logic [OW-1:0]     ord_waddr, ord_raddr;
  logic [AXIS_W-1:0] ord_axis;

  // Rank unit
  logic signed [COORD_W-1:0] key_r, c_sel;
  logic [AW-1:0]             key_idx_r, cmp_q_r;
  logic                      cmp_v_r;
  logic [CW-1:0]             rank_r;
  logic                      lt;

  // Box sweep and cost
  logic signed [COORD_W-1:0] lo_r [3];
  logic signed [COORD_W-1:0] hi_r [3];
  logic [EXT_W-1:0]          ext [3];
  logic [PROD_W-1:0]         p01_r, p02_r, p12_r;
  logic [AREA_W-1:0]         area_r, suf_r;
  logic [MW-1:0]             cl_r, cr_r;
  logic [COST_W-1:0]         cost, best_cost_r;
  logic [AW-1:0]             best_pos_r;
  logic [AXIS_W-1:0]         best_axis_r;
  logic [CW-1:0]             lw, rw;
  logic [LEFT_W-1:0]         left;

  // Output register
  logic                out_valid_r, out_sv_r, out_last_r;
  logic [ID_W-1:0]     out_id_r;
  logic [LEFT_W-1:0]   out_left_r;
  logic [AXIS_W-1:0]   out_axis_r;

  // Stores
  sah_ram #(.W(ID_W), .D(MAX_PRIMS)) u_id_ram (
    .clk, .we(cmd.ld_we), .waddr(idx), .wdata(in_prim_id),
    .raddr(ord_rdata), .rdata(id_rdata)
  );
  sah_ram #(.W(VEC_W), .D(MAX_PRIMS)) u_min_ram (
    .clk, .we(cmd.ld_we), .waddr(idx), .wdata({in_min_z, in_min_y, in_min_x}),
    .raddr(ord_rdata), .rdata(min_rdata)
  );
  sah_ram #(.W(VEC_W), .D(MAX_PRIMS)) u_max_ram (
    .clk, .we(cmd.ld_we), .waddr(idx), .wdata({in_max_z, in_max_y, in_max_x}),
    .raddr(ord_rdata), .rdata(max_rdata)
  );
  sah_ram #(.W(VEC_W), .D(MAX_PRIMS)) u_ctr_ram (
    .clk, .we(cmd.ld_we), .waddr(idx),
    .wdata({in_center_z, in_center_y, in_center_x}),
    .raddr(idx), .rdata(ctr_rdata)
  );

  assign ord_axis  = cmd.emit ? best_axis_r : axis;
  assign ord_waddr = {axis, rank_r[AW-1:0]};
  assign ord_raddr = {ord_axis, idx};

  sah_ram #(.W(AW), .D(2 ** OW)) u_ord_ram (
    .clk, .we(cmd.ord_we), .waddr(ord_waddr), .wdata(key_idx_r),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );
  sah_ram #(.W(AREA_W), .D(MAX_PRIMS)) u_suf_ram (
    .clk, .we(cmd.suf_we), .waddr(idx), .wdata(area_r),
    .raddr(idx + AW'(1)), .rdata(suf_rdata)
  );

  // Rank: count centers that sort ahead of the key (stable on index)
  assign c_sel = axis_pick(ctr_rdata, axis);
  assign lt    = (c_sel < key_r) || ((c_sel == key_r) && (cmp_q_r < key_idx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.cmp_en;
    end
  end

  always_ff @(posedge clk) begin
    cmp_q_r <= idx;
    if (cmd.key_idx_ld) begin
      key_idx_r <= idx;
    end
    if (cmd.key_ld) begin
      key_r  <= c_sel;
      rank_r <= '0;
    end else if (cmp_v_r && lt) begin
      rank_r <= rank_r + CW'(1);
    end
  end

  // Running box
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.box_first) begin
        lo_r[a] <= min_rdata[a*COORD_W +: COORD_W];
        hi_r[a] <= max_rdata[a*COORD_W +: COORD_W];
      end else if (cmd.box_grow) begin
        if ($signed(min_rdata[a*COORD_W +: COORD_W]) < lo_r[a]) begin
          lo_r[a] <= min_rdata[a*COORD_W +: COORD_W];
        end
        if ($signed(max_rdata[a*COORD_W +: COORD_W]) > hi_r[a]) begin
          hi_r[a] <= max_rdata[a*COORD_W +: COORD_W];
        end
      end
    end
  end

  // Extents, clamped at zero for inverted boxes
  always_comb begin
    logic signed [COORD_W:0] d;
    for (int a = 0; a < 3; a++) begin
      d = {hi_r[a][COORD_W-1], hi_r[a]} - {lo_r[a][COORD_W-1], lo_r[a]};
      ext[a] = d[COORD_W] ? '0 : d[EXT_W-1:0];
    end
  end

  // Surface area: products, then sum
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p01_r <= ext[0] * ext[1];
      p02_r <= ext[0] * ext[2];
      p12_r <= ext[1] * ext[2];
    end
    if (cmd.sum_en) begin
      area_r <= {1'b0, {2'b0, p01_r} + {2'b0, p02_r} + {2'b0, p12_r}, 1'b0};
    end
    if (cmd.suf_ld) begin
      suf_r <= suf_rdata;
    end
  end

  // Split cost
  assign lw   = CW'(idx) + CW'(1);
  assign rw   = n - lw;
  assign cost = COST_W'(cl_r) + COST_W'(cr_r);

  always_ff @(posedge clk) begin
    if (cmd.cost_en) begin
      cl_r <= MW'(area_r) * MW'(lw);
      cr_r <= MW'(suf_r) * MW'(rw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_cost_r <= COST_ONES;
      best_pos_r  <= '0;
      best_axis_r <= AXIS_X;
    end else if (cmd.best_clr) begin
      best_cost_r <= COST_ONES;
      best_pos_r  <= '0;
      best_axis_r <= AXIS_X;
    end else if (cmd.best_upd && (cost <= best_cost_r)) begin
      best_cost_r <= cost;
      best_pos_r  <= idx;
      best_axis_r <= axis;
    end
  end

  assign left         = LEFT_W'(best_pos_r) + LEFT_W'(1);
  assign sts.split_ok = (left != LEFT_W'(1)) && (left != LEFT_W'(n));
  assign sts.out_free = !out_valid_r || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_id_r   <= cmd.out_inv ? '0 : id_rdata;
      out_sv_r   <= !cmd.out_inv;
      out_left_r <= left;
      out_axis_r <= best_axis_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prim_id     = out_id_r;
  assign out_split_valid = out_sv_r;
  assign out_left_count  = out_left_r;
  assign out_best_axis   = out_axis_r;
  assign out_last_out    = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/sah_ctrl.sv
// ----------------------------------------------------------------------------
// sah_ctrl: sequencer of the split search
// Loads the set, then per axis ranks the centers, sweeps suffix areas and
// scores prefix splits, and finally streams the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sah_ctrl #(
  parameter int MAX_PRIMS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_last_in,
  output logic                                 in_ready,
  output sah_pkg::sah_cmd_t                    cmd,
  output logic [$clog2(MAX_PRIMS)-1:0]         idx,
  output logic [sah_pkg::AXIS_W-1:0]           axis,
  output logic [$clog2(MAX_PRIMS+1)-1:0]       n,
  input  wire sah_pkg::sah_sts_t               sts
);
  import sah_pkg::*;

  localparam int AW = $clog2(MAX_PRIMS);
  localparam int CW = $clog2(MAX_PRIMS + 1);

  typedef enum logic [23:0] {
    S_LOAD    = 24'h000001,
    S_RK_KEY  = 24'h000002,
    S_RK_KEYL = 24'h000004,
    S_RK_SCAN = 24'h000008,
    S_RK_FIN  = 24'h000010,
    S_RK_WR   = 24'h000020,
    S_SF_ORD  = 24'h000040,
    S_SF_BOX  = 24'h000080,
    S_SF_GROW = 24'h000100,
    S_SF_MUL  = 24'h000200,
    S_SF_SUM  = 24'h000400,
    S_SF_WR   = 24'h000800,
    S_PF_ORD  = 24'h001000,
    S_PF_BOX  = 24'h002000,
    S_PF_GROW = 24'h004000,
    S_PF_MUL  = 24'h008000,
    S_PF_SUM  = 24'h010000,
    S_PF_COST = 24'h020000,
    S_PF_CMP  = 24'h040000,
    S_EM_CHK  = 24'h080000,
    S_EM_ORD  = 24'h100000,
    S_EM_ID   = 24'h200000,
    S_EM_OUT  = 24'h400000,
    S_EM_INV  = 24'h800000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt, n_r, n_nxt;
  logic [AW-1:0]     p_r, p_nxt, j_r, j_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic              room, j_last, p_last, j_pf_last;

  assign room      = cnt_r < CW'(MAX_PRIMS);
  assign j_last    = (CW'(j_r) + CW'(1)) == n_r;
  assign p_last    = (CW'(p_r) + CW'(1)) == n_r;
  assign j_pf_last = (CW'(j_r) + CW'(2)) == n_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    idx       = j_r;
    in_ready  = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        idx      = cnt_r[AW-1:0];
        if (in_valid) begin
          cmd.ld_we = room;
          cnt_nxt   = room ? cnt_r + CW'(1) : cnt_r;
          if (in_last_in) begin
            n_nxt        = cnt_nxt;
            cnt_nxt      = '0;
            axis_nxt     = AXIS_X;
            p_nxt        = '0;
            cmd.best_clr = 1'b1;
            state_nxt    = S_RK_KEY;
          end
        end
      end

      // Rank of primitive p on this axis
      S_RK_KEY: begin
        idx            = p_r;
        cmd.key_idx_ld = 1'b1;
        state_nxt      = S_RK_KEYL;
      end
      S_RK_KEYL: begin
        idx        = '0;
        cmd.key_ld = 1'b1;
        cmd.cmp_en = 1'b1;
        j_nxt      = AW'(1);
        state_nxt  = (n_r == CW'(1)) ? S_RK_FIN : S_RK_SCAN;
      end
      S_RK_SCAN: begin
        cmd.cmp_en = 1'b1;
        j_nxt      = j_r + AW'(1);
        if (j_last) begin
          state_nxt = S_RK_FIN;
        end
      end
      S_RK_FIN: begin
        state_nxt = S_RK_WR;
      end
      S_RK_WR: begin
        cmd.ord_we = 1'b1;
        if (p_last) begin
          j_nxt     = AW'(n_r - CW'(1));
          state_nxt = S_SF_ORD;
        end else begin
          p_nxt     = p_r + AW'(1);
          state_nxt = S_RK_KEY;
        end
      end

      // Suffix sweep, last sorted position first
      S_SF_ORD:  state_nxt = S_SF_BOX;
      S_SF_BOX:  state_nxt = S_SF_GROW;
      S_SF_GROW: begin
        cmd.box_first = j_last;
        cmd.box_grow  = !j_last;
        state_nxt     = S_SF_MUL;
      end
      S_SF_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_SF_SUM;
      end
      S_SF_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_SF_WR;
      end
      S_SF_WR: begin
        cmd.suf_we = 1'b1;
        if (j_r != '0) begin
          j_nxt     = j_r - AW'(1);
          state_nxt = S_SF_ORD;
        end else if (n_r >= CW'(2)) begin
          state_nxt = S_PF_ORD;
        end else if (axis_r == AXIS_Z) begin
          state_nxt = S_EM_CHK;
        end else begin
          axis_nxt  = axis_r + AXIS_W'(1);
          p_nxt     = '0;
          state_nxt = S_RK_KEY;
        end
      end

      // Prefix sweep and split scoring
      S_PF_ORD: state_nxt = S_PF_BOX;
      S_PF_BOX: begin
        cmd.suf_ld = 1'b1;
        state_nxt  = S_PF_GROW;
      end
      S_PF_GROW: begin
        cmd.box_first = (j_r == '0);
        cmd.box_grow  = (j_r != '0);
        state_nxt     = S_PF_MUL;
      end
      S_PF_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_PF_SUM;
      end
      S_PF_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_PF_COST;
      end
      S_PF_COST: begin
        cmd.cost_en = 1'b1;
        state_nxt   = S_PF_CMP;
      end
      S_PF_CMP: begin
        cmd.best_upd = 1'b1;
        if (!j_pf_last) begin
          j_nxt     = j_r + AW'(1);
          state_nxt = S_PF_ORD;
        end else if (axis_r == AXIS_Z) begin
          state_nxt = S_EM_CHK;
        end else begin
          axis_nxt  = axis_r + AXIS_W'(1);
          p_nxt     = '0;
          state_nxt = S_RK_KEY;
        end
      end

      // Result stream
      S_EM_CHK: begin
        j_nxt     = '0;
        state_nxt = sts.split_ok ? S_EM_ORD : S_EM_INV;
      end
      S_EM_ORD: begin
        cmd.emit  = 1'b1;
        state_nxt = S_EM_ID;
      end
      S_EM_ID: begin
        cmd.emit  = 1'b1;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_last = j_last;
          if (j_last) begin
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + AW'(1);
            state_nxt = S_EM_ORD;
          end
        end
      end
      S_EM_INV: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_inv  = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      p_r     <= '0;
      j_r     <= '0;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      p_r     <= p_nxt;
      j_r     <= j_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign axis = axis_r;
  assign n    = n_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PRIMS))
    else $error("load count beyond capacity");

  a_set_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (n_r != '0))
    else $error("search running on an empty set");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("output register overwritten");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ord_we || cmd.best_upd) |-> (axis_r != 2'd3))
    else $error("axis counter out of range");

endmodule

`default_nettype wire

### hw/rtl/sah_sweep_split_finder.sv
// ----------------------------------------------------------------------------
// sah_sweep_split_finder: SAH sweep split search over a primitive set
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one primitive per transfer, one per
//    cycle while loading. in_last_in closes the set and starts the search.
//    Primitives beyond MAX_PRIMS are dropped; a dropped last item still
//    starts the search.
//  - Search on n primitives, per axis: ranking (one center compare per cycle
//    through the center store read port), then the suffix sweep, then the
//    prefix scoring. in_ready is low during the search and the result stream.
//  - Result channel (out_valid/out_ready): n results in the chosen order, or a
//    single result with out_split_valid low. Each result needs an order
//    store read, an id store read and the output load, plus any stall.
//  - A stalled receiver holds the output register; the block waits. After
//    the last result is loaded the block accepts primitives again while that
//    result still waits to be taken.
//  - Reset (rst_n low, synchronous) empties the set and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sah_sweep_split_finder #(
  parameter int MAX_PRIMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_prim_id,
  input  wire logic signed [15:0] in_min_x,
  input  wire logic signed [15:0] in_min_y,
  input  wire logic signed [15:0] in_min_z,
  input  wire logic signed [15:0] in_max_x,
  input  wire logic signed [15:0] in_max_y,
  input  wire logic signed [15:0] in_max_z,
  input  wire logic signed [15:0] in_center_x,
  input  wire logic signed [15:0] in_center_y,
  input  wire logic signed [15:0] in_center_z,
  input  wire logic               in_last_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_prim_id,
  output logic                    out_split_valid,
  output logic [6:0]              out_left_count,
  output logic [1:0]              out_best_axis,
  output logic                    out_last_out
);
  import sah_pkg::*;

  localparam int AW = $clog2(MAX_PRIMS);
  localparam int CW = $clog2(MAX_PRIMS + 1);

  sah_cmd_t          cmd;
  sah_sts_t          sts;
  logic [AW-1:0]     idx;
  logic [AXIS_W-1:0] axis;
  logic [CW-1:0]     n;

  sah_ctrl #(.MAX_PRIMS(MAX_PRIMS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_last_in, .in_ready,
    .cmd, .idx, .axis, .n, .sts
  );

  sah_datapath #(.MAX_PRIMS(MAX_PRIMS)) u_dp (
    .clk, .rst_n, .cmd, .idx, .axis, .n, .sts,
    .in_prim_id, .in_min_x, .in_min_y, .in_min_z,
    .in_max_x, .in_max_y, .in_max_z,
    .in_center_x, .in_center_y, .in_center_z,
    .out_ready, .out_valid, .out_prim_id, .out_split_valid,
    .out_left_count, .out_best_axis, .out_last_out
  );

endmodule

`default_nettype wire

### tb/sah_sweep_split_finder_tb.sv
// ----------------------------------------------------------------------------
// sah_sweep_split_finder_tb: self-checking bench for the SAH split finder
// Loads primitive sets through the input channel, predicts the best split
// and the id order per set, and checks every result transfer field by field.
// Random idling on both channels; one long stretch runs without gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module sah_sweep_split_finder_tb;
  import sah_pkg::*;

  localparam int MAXP       = 64;
  localparam int STALL_LIM  = 60000;
  localparam longint COST_MAX = 64'h0000_0FFF_FFFF_FFFF;

  typedef struct {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] mn [3];
    logic signed [COORD_W-1:0] mx [3];
    logic signed [COORD_W-1:0] ct [3];
    bit                        last;
    bit                        drain;  // wait for all results before sending
  } prim_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic              ok;
    logic [LEFT_W-1:0] left;
    logic [AXIS_W-1:0] axis;
    logic              last;
  } split_res_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_last_in;
  logic [15:0] in_prim_id;
  logic signed [15:0] in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z;
  logic signed [15:0] in_center_x, in_center_y, in_center_z;
  logic out_valid, out_ready;
  logic [15:0] out_prim_id;
  logic out_split_valid, out_last_out;
  logic [6:0] out_left_count;
  logic [1:0] out_best_axis;

  sah_sweep_split_finder #(.MAX_PRIMS(MAXP)) uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_prim_id,
    .in_min_x, .in_min_y, .in_min_z, .in_max_x, .in_max_y, .in_max_z,
    .in_center_x, .in_center_y, .in_center_z, .in_last_in,
    .out_valid, .out_ready, .out_prim_id, .out_split_valid,
    .out_left_count, .out_best_axis, .out_last_out
  );

  prim_t      prim_q [$];   // items waiting to be sent
  prim_t      set_q [$];    // primitives held by the block
  split_res_t split_q [$];  // expected results, oldest first
  prim_t      cur;
  bit         in_taken;
  int         n_sent, n_total, idle_cnt, cyc;
  bit         failed;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Surface area of a box, negative extents count as zero
  function automatic longint box_area(int lo[3], int hi[3]);
    longint e[3];
    for (int a = 0; a < 3; a++) e[a] = (hi[a] > lo[a]) ? longint'(hi[a] - lo[a]) : 0;
    return 2 * (e[0] * e[1] + e[0] * e[2] + e[1] * e[2]);
  endfunction

  // Search the held set and queue the expected result stream
  function automatic void split_predict();
    int n, pos, ax, key, j, left;
    int ord [3][MAXP];
    longint suf [MAXP];
    longint best, cost;
    int lo[3], hi[3];
    split_res_t r;
    n = set_q.size();
    best = COST_MAX; pos = 0; ax = 0;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < n; i++) ord[a][i] = i;
      for (int i = 1; i < n; i++) begin
        key = ord[a][i]; j = i;
        while (j > 0 && set_q[ord[a][j-1]].ct[a] > set_q[key].ct[a]) begin
          ord[a][j] = ord[a][j-1]; j--;
        end
        ord[a][j] = key;
      end
      for (int k = n - 1; k >= 0; k--) begin
        for (int b = 0; b < 3; b++) begin
          if (k == n - 1 || set_q[ord[a][k]].mn[b] < lo[b]) lo[b] = int'(set_q[ord[a][k]].mn[b]);
          if (k == n - 1 || set_q[ord[a][k]].mx[b] > hi[b]) hi[b] = int'(set_q[ord[a][k]].mx[b]);
        end
        suf[k] = box_area(lo, hi);
      end
      for (int i = 0; i + 1 < n; i++) begin
        for (int b = 0; b < 3; b++) begin
          if (i == 0 || set_q[ord[a][i]].mn[b] < lo[b]) lo[b] = int'(set_q[ord[a][i]].mn[b]);
          if (i == 0 || set_q[ord[a][i]].mx[b] > hi[b]) hi[b] = int'(set_q[ord[a][i]].mx[b]);
        end
        cost = box_area(lo, hi) * (i + 1) + suf[i+1] * (n - i - 1);
        if (cost <= best) begin
          best = cost; pos = i; ax = a;
        end
      end
    end
    left = pos + 1;
    if (left == 1 || left == n) begin
      r = '{id: '0, ok: 1'b0, left: left[LEFT_W-1:0], axis: ax[AXIS_W-1:0], last: 1'b1};
      split_q.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r = '{id: set_q[ord[ax][i]].id, ok: 1'b1, left: left[LEFT_W-1:0],
              axis: ax[AXIS_W-1:0], last: (i == n - 1)};
        split_q.push_back(r);
      end
    end
    set_q.delete();
  endfunction

  task automatic add_prim(input logic [15:0] id, input int lo, input int hi,
                          input int c, input bit last, input bit drain);
    prim_t p;
    p.id = id; p.last = last; p.drain = drain;
    for (int a = 0; a < 3; a++) begin
      p.mn[a] = COORD_W'(lo); p.mx[a] = COORD_W'(hi); p.ct[a] = COORD_W'(c);
    end
    prim_q.push_back(p);
  endtask

  // Random set; mostly well-formed boxes, some raw noise
  task automatic add_set(input int n, input bit drain);
    prim_t p;
    int lo, ext;
    for (int i = 0; i < n; i++) begin
      p.id = ID_W'($urandom);
      p.last = (i == n - 1);
      p.drain = drain && (i == 0);
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(0, 9) == 0) begin
          p.mn[a] = COORD_W'($urandom);
          p.mx[a] = COORD_W'($urandom);
          p.ct[a] = COORD_W'($urandom);
        end else begin
          lo  = $urandom_range(0, 65535) - 32768;
          ext = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 65535 : 2000);
          if (lo + ext > 32767) ext = 32767 - lo;
          p.mn[a] = COORD_W'(lo); p.mx[a] = COORD_W'(lo + ext);
          p.ct[a] = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                           : lo + ext / 2);
        end
      end
      prim_q.push_back(p);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int sz;
    rst_n = 0; failed = 0;
    // single primitive: always an unusable split
    add_prim(16'h0000, -32768, 32767, 0, 1, 0);
    // two primitives: left count 1 at best
    add_prim(16'hFFFF, -32768, -32768, -32768, 0, 0);
    add_prim(16'h5A5A, 32767, 32767, 32767, 1, 0);
    // inverted boxes and equal centers: ties go to the later axis/position
    add_prim(16'h0001, 100, -100, 5, 0, 0);
    add_prim(16'h0002, 100, -100, 5, 0, 0);
    add_prim(16'h0003, 100, -100, 5, 1, 0);
    // clearly separated clusters
    add_prim(16'h0010, -32768, -30000, -31000, 0, 0);
    add_prim(16'h0011, -32000, -29000, -30500, 0, 0);
    add_prim(16'h0012, 29000, 32767, 31000, 0, 0);
    add_prim(16'h0013, 30000, 32767, 31500, 1, 1);
    add_set(6, 0);
    add_set(4, 1);
    while (prim_q.size() < 45) begin
      sz = $urandom_range(1, 8);
      add_set(sz, $urandom_range(0, 7) == 0);
    end
    // full set plus one: the dropped last primitive starts the search
    add_set(MAXP + 1, 1);
    n_total = prim_q.size();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    while (n_sent < n_total || split_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Monitor: transfers, prediction, checks, watchdog
  always @(posedge clk) begin
    split_res_t e;
    cyc++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (set_q.size() < MAXP) set_q.push_back(cur);
        if (cur.last) split_predict();
        in_taken = 1;
        n_sent++;
      end
      if (out_valid && out_ready) begin
        if (split_q.size() == 0) begin
          $display("%0t: unexpected result id=%h", $time, out_prim_id);
          failed = 1;
        end else begin
          e = split_q.pop_front();
          if (out_prim_id !== e.id || out_split_valid !== e.ok ||
              out_left_count !== e.left || out_best_axis !== e.axis ||
              out_last_out !== e.last) begin
            $display("%0t: mismatch exp id=%h ok=%b left=%0d axis=%0d last=%b",
                     $time, e.id, e.ok, e.left, e.axis, e.last);
            $display("%0t:          got id=%h ok=%b left=%0d axis=%0d last=%b",
                     $time, out_prim_id, out_split_valid, out_left_count,
                     out_best_axis, out_last_out);
            failed = 1;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= STALL_LIM) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Driver: presents queued items at the falling edge, random gaps
  always @(negedge clk) begin
    bit quiet;
    quiet = (cyc > 1000 && cyc < 3000);
    if (!rst_n) begin
      in_valid <= 0; in_taken = 0; out_ready <= 0; in_last_in <= 0;
      in_prim_id <= 0; in_min_x <= 0; in_min_y <= 0; in_min_z <= 0;
      in_max_x <= 0; in_max_y <= 0; in_max_z <= 0;
      in_center_x <= 0; in_center_y <= 0; in_center_z <= 0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 13);
      if (!in_valid || in_taken) begin
        in_taken = 0;
        if (prim_q.size() != 0 && !(prim_q[0].drain && split_q.size() != 0) &&
            (quiet || $urandom_range(0, 99) >= 13)) begin
          cur = prim_q.pop_front();
          in_prim_id <= cur.id;
          in_min_x <= cur.mn[0]; in_min_y <= cur.mn[1]; in_min_z <= cur.mn[2];
          in_max_x <= cur.mx[0]; in_max_y <= cur.mx[1]; in_max_z <= cur.mx[2];
          in_center_x <= cur.ct[0]; in_center_y <= cur.ct[1]; in_center_z <= cur.ct[2];
          in_last_in <= cur.last;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/sah_pkg.sv
hw/rtl/sah_ram.sv
hw/rtl/sah_datapath.sv
hw/rtl/sah_ctrl.sv
hw/rtl/sah_sweep_split_finder.sv
tb/sah_sweep_split_finder_tb.sv
